[hw/rtl/sbus_pkg.sv]
// shared types and constants of the sbus frame receiver
`default_nettype none

package sbus_pkg;

  // frame layout
  localparam int FRAME_BYTES_DEF = 25;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;

  // channel unpacking and scaling
  localparam int NUM_CH     = 16;
  localparam int CH_BITS    = 11;
  localparam int RAW_MID    = 992;
  localparam int NORM_LIMIT = 1000;

  // field widths
  localparam int TIMEOUT_W = 16;
  localparam int FRAMES_W  = 32;
  localparam int CH_IDX_W  = 4;
  localparam int FLAGS_W   = 4;

  // register reset value
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_LINE_ERR = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_CHANNEL = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

endpackage

`default_nettype wire

[hw/rtl/sbus_if.sv]
// valid/ready channel interfaces of the sbus frame receiver
`default_nettype none

// input item channel
interface sbus_in_if import sbus_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

// result item channel
interface sbus_out_if import sbus_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [CH_IDX_W-1:0]        channel_index;
  logic signed [CH_BITS-1:0]  channel_value;
  logic                       digital_ch17;
  logic                       digital_ch18;
  logic                       lost_frame_flag;
  logic                       failsafe_flag;
  logic                       link_online;
  logic [FRAMES_W-1:0]        frames_received;
  logic                       last;

  modport source (output valid, kind, channel_index, channel_value, digital_ch17,
                  digital_ch18, lost_frame_flag, failsafe_flag, link_online,
                  frames_received, last, input ready);
  modport sink   (input valid, kind, channel_index, channel_value, digital_ch17,
                  digital_ch18, lost_frame_flag, failsafe_flag, link_online,
                  frames_received, last, output ready);
endinterface

// configuration write channel
interface sbus_cfg_if import sbus_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] timeout_ms;

  modport source (output valid, timeout_ms, input ready);
  modport sink   (input valid, timeout_ms, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbus_norm.sv]
// channel scaler: (raw-992)*5/4 truncated toward zero, clamped to +-1000
`default_nettype none

module sbus_norm import sbus_pkg::*; (
  input  logic [CH_BITS-1:0]        raw,
  output logic signed [CH_BITS-1:0] value
);

  logic signed [CH_BITS:0]   diff;
  logic signed [CH_BITS+2:0] prod;
  logic signed [CH_BITS+2:0] biased;
  logic signed [CH_BITS+2:0] quot;

  // center, scale by five, divide by four rounding toward zero
  always_comb begin
    diff   = $signed({1'b0, raw}) - $signed((CH_BITS+1)'(RAW_MID));
    prod   = ($signed((CH_BITS+3)'(diff)) <<< 2) + $signed((CH_BITS+3)'(diff));
    biased = prod[CH_BITS+2] ? prod + $signed((CH_BITS+3)'(3)) : prod;
    quot   = biased >>> 2;
    if (quot > $signed((CH_BITS+3)'(NORM_LIMIT))) begin
      value = CH_BITS'(NORM_LIMIT);
    end else if (quot < -$signed((CH_BITS+3)'(NORM_LIMIT))) begin
      value = -$signed(CH_BITS'(NORM_LIMIT));
    end else begin
      value = quot[CH_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sbus_frame_receiver_core.sv]
// sbus frame receiver: frame collection, channel unpacking, link timeout
// A received byte, a line error or a tick is taken while the block is idle; apart
// from a completing good frame it stays idle, and a tick loads one status result.
// A frame with a good footer holds the block, plus any output stall, until its
// last channel is loaded: the 22 channel bytes are read back from the frame store
// one at a time via S_READ and S_LOAD (single read port, registered data) into a
// bit buffer, and each of the 16 channels passes through the one shared scaler in
// an S_EMIT step of its own. The next input is taken once the output register is
// free or being emptied. The timeout register may be written at any time.
`default_nettype none

module sbus_frame_receiver_core import sbus_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  sbus_cfg_if.sink   cfg,
  sbus_in_if.sink    rx,
  sbus_out_if.source res
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int BUF_W = CH_BITS + 8;
  localparam int CNT_W = $clog2(BUF_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t                    state;
  logic [POS_W-1:0]          pos;
  logic [FLAGS_W-1:0]        flags;
  logic [FLAGS_W-1:0]        flags_pending;
  logic                      online;
  logic [COUNT_WIDTH-1:0]    good_frames;
  logic [TIMEOUT_W-1:0]      elapsed;
  logic [TIMEOUT_W-1:0]      timeout_ms;

  logic [7:0]                frame_store [FRAME_BYTES];
  logic [POS_W-1:0]          rd_addr;
  logic [7:0]                rd_data;

  logic [BUF_W-1:0]          bit_buf;
  logic [CNT_W-1:0]          bit_cnt;
  logic [CH_IDX_W-1:0]       ch;

  logic                      out_valid;
  kind_t                     out_kind;
  logic [CH_IDX_W-1:0]       out_index;
  logic signed [CH_BITS-1:0] out_value;
  logic                      out_last;

  logic                      in_xfer;
  logic                      out_free;
  logic                      out_load;
  opcode_t                   op;
  logic [TIMEOUT_W-1:0]      elapsed_next;
  logic [CNT_W-1:0]          bit_rem;
  logic signed [CH_BITS-1:0] norm_value;

  // configuration register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ms <= cfg.timeout_ms;
    end
  end

  // handshake terms
  assign out_free = !out_valid || res.ready;
  assign rx.ready = (state == S_IDLE) && out_free;
  assign in_xfer  = rx.valid && rx.ready;
  assign op       = opcode_t'(rx.opcode);
  assign out_load = (in_xfer && op == OP_TICK) || (state == S_EMIT && out_free);

  // saturating tick count and bits left after one channel
  assign elapsed_next = (elapsed == {TIMEOUT_W{1'b1}}) ? elapsed : elapsed + TIMEOUT_W'(1);
  assign bit_rem      = bit_cnt - CNT_W'(CH_BITS);

  // shared channel scaler
  sbus_norm u_norm (
    .raw   (bit_buf[CH_BITS-1:0]),
    .value (norm_value)
  );

  // frame store: write on byte transfer, registered read
  always_ff @(posedge clk) begin
    if (in_xfer && op == OP_BYTE && (pos != '0 || rx.rx_byte == HDR_BYTE)) begin
      frame_store[pos] <= rx.rx_byte;
    end
    rd_data <= frame_store[rd_addr];
  end

  // sequencer, link state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      flags       <= '0;
      online      <= 1'b0;
      good_frames <= '0;
      elapsed     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (op)
              OP_BYTE: begin
                if (pos != '0 || rx.rx_byte == HDR_BYTE) begin
                  if (pos == POS_W'(FRAME_BYTES - 2)) begin
                    flags_pending <= rx.rx_byte[7:4];
                  end
                  if (pos == POS_W'(FRAME_BYTES - 1)) begin
                    pos <= '0;
                    if (rx.rx_byte == FTR_BYTE) begin
                      flags       <= flags_pending;
                      online      <= 1'b1;
                      elapsed     <= '0;
                      good_frames <= good_frames + COUNT_WIDTH'(1);
                      rd_addr     <= POS_W'(1);
                      bit_buf     <= '0;
                      bit_cnt     <= '0;
                      ch          <= '0;
                      state       <= S_READ;
                    end
                  end else begin
                    pos <= pos + POS_W'(1);
                  end
                end
              end
              OP_LINE_ERR: begin
                pos <= '0;
              end
              OP_TICK: begin
                elapsed <= elapsed_next;
                if (elapsed_next > timeout_ms) begin
                  online <= 1'b0;
                end
                out_kind  <= KIND_STATUS;
                out_index <= '0;
                out_value <= '0;
                out_last  <= 1'b1;
              end
              OP_UNUSED: begin
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          bit_buf <= bit_buf | (BUF_W'(rd_data) << bit_cnt);
          bit_cnt <= bit_cnt + CNT_W'(8);
          rd_addr <= rd_addr + POS_W'(1);
          state   <= (bit_cnt + CNT_W'(8) >= CNT_W'(CH_BITS)) ? S_EMIT : S_READ;
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind  <= KIND_CHANNEL;
            out_index <= ch;
            out_value <= norm_value;
            out_last  <= (ch == CH_IDX_W'(NUM_CH - 1));
            bit_buf   <= bit_buf >> CH_BITS;
            bit_cnt   <= bit_rem;
            ch        <= ch + CH_IDX_W'(1);
            if (ch == CH_IDX_W'(NUM_CH - 1)) begin
              state <= S_IDLE;
            end else if (bit_rem >= CNT_W'(CH_BITS)) begin
              state <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result channel; link fields hold still while a result waits
  assign res.valid           = out_valid;
  assign res.kind            = out_kind;
  assign res.channel_index   = out_index;
  assign res.channel_value   = out_value;
  assign res.digital_ch17    = flags[3];
  assign res.digital_ch18    = flags[2];
  assign res.lost_frame_flag = flags[1];
  assign res.failsafe_flag   = flags[0];
  assign res.link_online     = online;
  assign res.frames_received = FRAMES_W'(good_frames);
  assign res.last            = out_last;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench of the sbus frame receiver core
`default_nettype none

module testbench import sbus_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // frame layout and scaling seen by the decoder
  localparam int CH_BYTES = 22;
  localparam int FLAG_POS = 23;
  localparam int SCALE    = 1000;
  localparam int SPAN     = 800;

  typedef logic [CH_BITS-1:0] raw_set_t [NUM_CH];

  typedef struct packed {
    kind_t                 kind;
    logic [CH_IDX_W-1:0]   idx;
    logic signed [CH_BITS-1:0] value;
    logic [FLAGS_W-1:0]    flags;
    logic                  online;
    logic [FRAMES_W-1:0]   frames;
    logic                  last;
  } sbus_result_t;

  logic clk = 1'b0;
  logic rst;

  sbus_cfg_if cfg_bus ();
  sbus_in_if  rx_bus ();
  sbus_out_if res_bus ();

  sbus_frame_receiver_core u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .rx  (rx_bus),
    .res (res_bus)
  );

  always #5 clk = ~clk;

  // decoder state mirrored by the testbench
  logic [7:0]          frame_mem [FRAME_BYTES_DEF];
  int                  collect_pos = 0;
  logic [FLAGS_W-1:0]  flag_bits = '0;
  logic                link_up = 1'b0;
  logic [FRAMES_W-1:0] frames_seen = '0;
  logic [TIMEOUT_W-1:0] ticks_since_frame = '0;
  logic [TIMEOUT_W-1:0] timeout_limit = TIMEOUT_RESET;

  sbus_result_t decoded_outputs [$];
  int mismatch_count = 0;
  int items_taken = 0;
  bit idle_enabled = 1'b1;
  int ready_hold_cycles = 0;

  function automatic sbus_result_t make_result(kind_t kind, int idx, int value, bit last);
    sbus_result_t r;
    r.kind   = kind;
    r.idx    = CH_IDX_W'(idx);
    r.value  = CH_BITS'(value);
    r.flags  = flag_bits;
    r.online = link_up;
    r.frames = frames_seen;
    r.last   = last;
    return r;
  endfunction

  // advance the decoder by one accepted item; returns 0 when the item is ignored
  function automatic bit rx_decode(opcode_t op, logic [7:0] data);
    logic [CH_BYTES*8-1:0] ch_bits;
    int scaled;
    case (op)
      OP_LINE_ERR: begin
        collect_pos = 0;
        return 1'b1;
      end
      OP_TICK: begin
        if (ticks_since_frame != '1) ticks_since_frame++;
        if (ticks_since_frame > timeout_limit) link_up = 1'b0;
        decoded_outputs.push_back(make_result(KIND_STATUS, 0, 0, 1'b1));
        return 1'b1;
      end
      OP_BYTE: begin
        // hunt for the header while idle
        if (collect_pos == 0 && data != HDR_BYTE) return 1'b0;
        frame_mem[collect_pos] = data;
        collect_pos++;
        if (collect_pos < FRAME_BYTES_DEF) return 1'b1;
        collect_pos = 0;
        // a bad footer drops the frame
        if (frame_mem[0] != HDR_BYTE || frame_mem[FRAME_BYTES_DEF-1] != FTR_BYTE) return 1'b1;
        flag_bits = frame_mem[FLAG_POS][7:4];
        link_up = 1'b1;
        ticks_since_frame = '0;
        frames_seen++;
        for (int k = 0; k < CH_BYTES; k++) ch_bits[k*8 +: 8] = frame_mem[k+1];
        // unpack, scale with truncation toward zero, clamp
        for (int ch = 0; ch < NUM_CH; ch++) begin
          scaled = (int'(ch_bits[ch*CH_BITS +: CH_BITS]) - RAW_MID) * SCALE / SPAN;
          if (scaled > NORM_LIMIT) scaled = NORM_LIMIT;
          if (scaled < -NORM_LIMIT) scaled = -NORM_LIMIT;
          decoded_outputs.push_back(make_result(KIND_CHANNEL, ch, scaled, ch == NUM_CH - 1));
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    sbus_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (decoded_outputs.size() == 0) begin
        $error("unexpected result: kind %0d index %0d", res_bus.kind, res_bus.channel_index);
        mismatch_count++;
      end else begin
        want = decoded_outputs.pop_front();
        check_field("kind", want.kind, res_bus.kind);
        check_field("channel_index", want.idx, res_bus.channel_index);
        check_field("channel_value", want.value, res_bus.channel_value);
        check_field("digital_ch17", want.flags[3], res_bus.digital_ch17);
        check_field("digital_ch18", want.flags[2], res_bus.digital_ch18);
        check_field("lost_frame_flag", want.flags[1], res_bus.lost_frame_flag);
        check_field("failsafe_flag", want.flags[0], res_bus.failsafe_flag);
        check_field("link_online", want.online, res_bus.link_online);
        check_field("frames_received", want.frames, res_bus.frames_received);
        check_field("last", want.last, res_bus.last);
      end
    end
  end

  // result side ready: random stalls, plus long holds on request
  initial begin : result_ready_driver
    int gap;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_hold_cycles > 0) begin
        res_bus.ready <= 1'b0;
        repeat (ready_hold_cycles) @(posedge clk);
        ready_hold_cycles = 0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 19);
        res_bus.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // one input transfer, followed now and then by an idle burst
  task automatic send_item(opcode_t op, logic [7:0] data);
    int gap;
    rx_bus.valid   <= 1'b1;
    rx_bus.opcode  <= op;
    rx_bus.rx_byte <= data;
    do @(posedge clk); while (!rx_bus.ready);
    if (rx_decode(op, data)) items_taken++;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom));
  endtask

  // pack sixteen raw channels into a frame; scramble mixes in ticks and line errors
  task automatic send_frame(raw_set_t raw, logic [7:0] flag_byte, logic [7:0] footer,
                            bit scramble);
    logic [CH_BYTES*8-1:0] ch_bits;
    logic [7:0] bytes [FRAME_BYTES_DEF];
    ch_bits = '0;
    for (int ch = 0; ch < NUM_CH; ch++) ch_bits[ch*CH_BITS +: CH_BITS] = raw[ch];
    bytes[0] = HDR_BYTE;
    for (int k = 0; k < CH_BYTES; k++) bytes[k+1] = ch_bits[k*8 +: 8];
    bytes[FLAG_POS] = flag_byte;
    bytes[FRAME_BYTES_DEF-1] = footer;
    for (int k = 0; k < FRAME_BYTES_DEF; k++) begin
      if (scramble && $urandom_range(0, 9) == 0) send_tick();
      if (scramble && k > 0 && $urandom_range(0, 59) == 0)
        send_item(OP_LINE_ERR, 8'($urandom));
      send_item(OP_BYTE, bytes[k]);
    end
  endtask

  function automatic raw_set_t random_channels();
    raw_set_t raw;
    logic [CH_BITS-1:0] corner_raws [11] = '{11'd0, 11'd191, 11'd192, 11'd193, 11'd991,
        11'd992, 11'd993, 11'd1791, 11'd1792, 11'd1793, 11'd2047};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if ($urandom_range(0, 3) == 0) raw[ch] = corner_raws[$urandom_range(0, 10)];
      else raw[ch] = CH_BITS'($urandom_range(0, 2047));
    end
    return raw;
  endfunction

  // stop sending and wait for every predicted result
  task automatic wait_results_done();
    rx_bus.valid <= 1'b0;
    @(posedge clk);
    while (decoded_outputs.size() != 0) @(posedge clk);
  endtask

  // register write only while the block is quiet
  task automatic write_timeout(logic [TIMEOUT_W-1:0] value);
    wait_results_done();
    repeat (80) @(posedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.timeout_ms <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    timeout_limit = value;
    cfg_bus.valid <= 1'b0;
  endtask

  // status at reset, ignored opcode, line error while idle, header hunt
  task automatic test_idle_inputs();
    send_tick();
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_LINE_ERR, 8'h0F);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hF0);
    send_tick();
  endtask

  // clamp limits, truncation on both sides of mid, all flags
  task automatic test_channel_extremes();
    raw_set_t corner = '{11'd0, 11'd2047, 11'd191, 11'd192, 11'd193, 11'd991, 11'd992,
        11'd993, 11'd1791, 11'd1792, 11'd1793, 11'd1, 11'd2046, 11'd1000, 11'd500, 11'd1500};
    send_frame(corner, 8'hF0, FTR_BYTE, 1'b0);
    send_tick();
  endtask

  // bad footer drops the frame without touching the count
  task automatic test_bad_footer();
    send_frame(random_channels(), 8'hA5, 8'h80, 1'b0);
    send_tick();
  endtask

  // line error mid-frame restarts collection at the header
  task automatic test_line_error();
    for (int k = 0; k < 5; k++) send_item(OP_BYTE, (k == 0) ? HDR_BYTE : 8'($urandom));
    send_item(OP_LINE_ERR, 8'($urandom));
    send_item(OP_BYTE, 8'h55);
    send_frame(random_channels(), 8'hC0, FTR_BYTE, 1'b0);
  endtask

  // aging against the maximum timeout, a zero timeout and the reset value
  task automatic test_link_timeout();
    write_timeout('1);
    repeat (2) send_tick();
    write_timeout('0);
    send_tick();
    write_timeout(TIMEOUT_RESET);
    send_tick();
  endtask

  // result side held off while frames and ticks keep coming
  task automatic test_backpressure();
    wait_results_done();
    ready_hold_cycles = 400;
    send_frame(random_channels(), 8'($urandom), FTR_BYTE, 1'b0);
    repeat (2) send_tick();
    wait_results_done();
  endtask

  // mostly well-formed frames with random content, some broken, some noise
  task automatic test_random(int n_items);
    int start;
    start = items_taken;
    while (items_taken - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_frame(random_channels(), 8'($urandom),
                     ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : FTR_BYTE,
                     1'b1);
        end
        6: send_tick();
        7: send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom));
        default: repeat ($urandom_range(1, 6)) send_tick();
      endcase
    end
  endtask

  // test sequence
  initial begin : main_sequence
    int guard;
    rst                <= 1'b1;
    rx_bus.valid       <= 1'b0;
    rx_bus.opcode      <= OP_BYTE;
    rx_bus.rx_byte     <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.timeout_ms <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_inputs();
    test_channel_extremes();
    test_bad_footer();
    test_line_error();
    test_link_timeout();
    test_backpressure();
    write_timeout(TIMEOUT_W'($urandom_range(1, 12)));
    idle_enabled = 1'b0;
    test_random(8);

    // drain and settle
    rx_bus.valid <= 1'b0;
    guard = 0;
    while (decoded_outputs.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    if (decoded_outputs.size() != 0) begin
      $error("%0d predicted results never arrived", decoded_outputs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** sbus_frame_receiver_core: PASSED **");
    end else begin
      $display("** sbus_frame_receiver_core: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin : run_limit
    #20_000_000;
    $display("** sbus_frame_receiver_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
